>>> design/nrls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrls_pkg
// Shared types and codes of the nested region latency statistics block.
// ----------------------------------------------------------------------------
package nrls_pkg;

    // Field widths fixed by the item layout
    localparam int REGION_W = 4;
    localparam int TS_W     = 48;
    localparam int AVG_W    = 64;
    localparam int CALLS_W  = 32;
    localparam int TOTAL_W  = 64;

    // Stream layout
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 248;
    localparam int OUT_DUR_LO = 4;
    localparam int OUT_AVG_LO = 52;
    localparam int OUT_MIN_LO = 116;
    localparam int OUT_MAX_LO = 164;
    localparam int OUT_CLS_LO = 212;
    localparam int OUT_CLS_HI = 243;

    typedef enum logic [1:0] {
        MODE_BEGIN = 2'd0,
        MODE_END   = 2'd1,
        MODE_RESET = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_NOCALL = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_POP,
        S_RDROW,
        S_LOAD,
        S_BEGIN,
        S_DUR,
        S_INS,
        S_TOT,
        S_WRITE,
        S_QCHK,
        S_TRIM,
        S_DIVGO,
        S_DIV,
        S_RES,
        S_OUT
    } t_state;

    typedef struct packed {
        logic cap;
        logic push;
        logic pop_rd;
        logic pop_take;
        logic row_rd;
        logic row_load;
        logic beg_upd;
        logic dur_calc;
        logic ins_step;
        logic tot_upd;
        logic row_wr;
        logic trim_init;
        logic trim_step;
        logic div_start;
        logic set_err;
        logic clr_used;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  calls_zero;
        logic  calls_small;
        logic  ins_last;
        logic  trim_last;
        logic  div_done;
        logic  out_taken;
    } t_sts;

endpackage

>>> design/nested_region_latency_statistics_top.sv
`timescale 1ns / 1ps
// Flow, accept to result beat: reset, full-stack begin and empty-stack end go
// straight to the result; a query with calls > 2*KEEP first trims the list
// entries from the total, and query time is set by the bit-serial divider.
// Throughput: one item at a time; the next beat is taken the cycle after the
// result beat leaves.
// Reset: synchronous, active low; clears stack level, region valid bits, out valid.
// ----------------------------------------------------------------------------
// nested_region_latency_statistics_top
// Per-region latency monitor with nested begin/end over a region stack,
// keeping count, total, KEEP smallest and KEEP largest durations per region.
// ----------------------------------------------------------------------------
module nested_region_latency_statistics_top #(
    parameter int REGIONS     = 16,
    parameter int KEEP        = 4,
    parameter int STACK_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [nrls_pkg::IN_DATA_W-1:0]    i_s_tdata,   // region[3:0], timestamp[51:4]
    input  logic [1:0]                        i_s_tuser,   // mode[1:0]
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [nrls_pkg::OUT_DATA_W-1:0]   o_m_tdata,   // region, duration, average,
                                                           // minimum, maximum, calls
    output logic [1:0]                        o_m_tuser    // status[1:0]
);
    import nrls_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    logic [1:0]          w_status;
    logic [REGION_W-1:0] w_region;
    logic [TS_W-1:0]     w_duration;
    logic [AVG_W-1:0]    w_average;
    logic [TS_W-1:0]     w_minimum;
    logic [TS_W-1:0]     w_maximum;
    logic [CALLS_W-1:0]  w_calls;

    // Sequencer: walks each item one step per cycle, waiting on divider and out ready.
    nrls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: stack, statistics rows, list insert, trim, divider, result.
    nrls_dpath #(
        .REGIONS     (REGIONS),
        .KEEP        (KEEP),
        .STACK_DEPTH (STACK_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_mode      (i_s_tuser),
        .i_region    (i_s_tdata[3:0]),
        .i_timestamp (i_s_tdata[51:4]),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_status    (w_status),
        .o_region    (w_region),
        .o_duration  (w_duration),
        .o_average   (w_average),
        .o_minimum   (w_minimum),
        .o_maximum   (w_maximum),
        .o_calls     (w_calls)
    );

    // Result beat packing, lowest field first, padded to whole bytes.
    assign o_m_tdata = {4'b0, w_calls, w_maximum, w_minimum, w_average,
                        w_duration, w_region};
    assign o_m_tuser = w_status;

endmodule

>>> design/nrls_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrls_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module nrls_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_sh;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_sh[31:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> design/nrls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrls_ctrl
// Sequencer: steps one item through stack, row access, update and result.
// ----------------------------------------------------------------------------
module nrls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nrls_pkg::t_sts i_sts,
    output nrls_pkg::t_cmd o_cmd
);
    import nrls_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                unique case (i_sts.mode)
                    MODE_BEGIN: n_state = i_sts.full ? S_RES : S_RDROW;
                    MODE_END:   n_state = i_sts.empty ? S_RES : S_POP;
                    MODE_RESET: n_state = S_RES;
                    MODE_QUERY: n_state = S_RDROW;
                    default:    n_state = S_RES;
                endcase
            end
            S_POP:   n_state = S_RDROW;
            S_RDROW: n_state = S_LOAD;
            S_LOAD: begin
                unique case (i_sts.mode)
                    MODE_BEGIN: n_state = S_BEGIN;
                    MODE_END:   n_state = S_DUR;
                    default:    n_state = S_QCHK;
                endcase
            end
            S_BEGIN: n_state = S_WRITE;
            S_DUR:   n_state = S_INS;
            S_INS:   if (i_sts.ins_last) n_state = S_TOT;
            S_TOT:   n_state = S_WRITE;
            S_WRITE: n_state = S_RES;
            S_QCHK: begin
                if (i_sts.calls_zero)       n_state = S_RES;
                else if (i_sts.calls_small) n_state = S_DIVGO;
                else                        n_state = S_TRIM;
            end
            S_TRIM:  if (i_sts.trim_last) n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV:   if (i_sts.div_done) n_state = S_RES;
            S_RES:   n_state = S_OUT;
            S_OUT:   if (i_sts.out_taken) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            S_DISP: begin
                unique case (i_sts.mode)
                    MODE_BEGIN: begin
                        o_cmd.set_err = i_sts.full;
                        o_cmd.push    = !i_sts.full;
                    end
                    MODE_END: begin
                        o_cmd.set_err = i_sts.empty;
                        o_cmd.pop_rd  = !i_sts.empty;
                    end
                    MODE_RESET: o_cmd.clr_used = 1'b1;
                    default:    o_cmd.set_err  = 1'b0;
                endcase
            end
            S_POP:   o_cmd.pop_take = 1'b1;
            S_RDROW: o_cmd.row_rd   = 1'b1;
            S_LOAD:  o_cmd.row_load = 1'b1;
            S_BEGIN: o_cmd.beg_upd  = 1'b1;
            S_DUR:   o_cmd.dur_calc = 1'b1;
            S_INS:   o_cmd.ins_step = 1'b1;
            S_TOT:   o_cmd.tot_upd  = 1'b1;
            S_WRITE: o_cmd.row_wr   = 1'b1;
            S_QCHK: begin
                o_cmd.set_err   = i_sts.calls_zero;
                o_cmd.trim_init = 1'b1;
            end
            S_TRIM:  o_cmd.trim_step = 1'b1;
            S_DIVGO: o_cmd.div_start = 1'b1;
            S_DIV:   o_cmd.cap       = 1'b0;
            S_RES:   o_cmd.res_load  = 1'b1;
            S_OUT:   o_cmd.cap       = 1'b0;
            default: o_cmd.cap       = 1'b0;
        endcase
    end

endmodule

>>> design/nrls_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrls_dpath
// Region stack, per-region statistics memory, list insertion, trim and result.
// ----------------------------------------------------------------------------
module nrls_dpath #(
    parameter int REGIONS     = 16,
    parameter int KEEP        = 4,
    parameter int STACK_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nrls_pkg::t_cmd                  i_cmd,
    output nrls_pkg::t_sts                  o_sts,
    input  logic [1:0]                      i_mode,
    input  logic [nrls_pkg::REGION_W-1:0]   i_region,
    input  logic [nrls_pkg::TS_W-1:0]       i_timestamp,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [1:0]                      o_status,
    output logic [nrls_pkg::REGION_W-1:0]   o_region,
    output logic [nrls_pkg::TS_W-1:0]       o_duration,
    output logic [nrls_pkg::AVG_W-1:0]      o_average,
    output logic [nrls_pkg::TS_W-1:0]       o_minimum,
    output logic [nrls_pkg::TS_W-1:0]       o_maximum,
    output logic [nrls_pkg::CALLS_W-1:0]    o_calls
);
    import nrls_pkg::*;

    localparam int DW  = TIME_BITS;
    localparam int RW  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int KW  = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int SW  = $clog2(2 * KEEP);
    localparam int LW  = $clog2(STACK_DEPTH + 1);
    localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // item
    t_mode          r_mode;
    logic [DW-1:0]  r_ts;
    logic [RW-1:0]  r_idx;
    t_status        r_stat;

    // stack
    logic [RW-1:0]  r_stack [STACK_DEPTH];
    logic [RW-1:0]  r_stk_q;
    logic [LW-1:0]  r_level;

    // statistics memory, one row per region
    logic [REGIONS-1:0]   r_used;
    logic [DW-1:0]        m_start [REGIONS];
    logic [TOTAL_W-1:0]   m_total [REGIONS];
    logic [CALLS_W-1:0]   m_calls [REGIONS];
    logic [KEEP*DW-1:0]   m_min   [REGIONS];
    logic [KEEP*DW-1:0]   m_max   [REGIONS];
    logic [DW-1:0]        r_q_start;
    logic [TOTAL_W-1:0]   r_q_total;
    logic [CALLS_W-1:0]   r_q_calls;
    logic [KEEP*DW-1:0]   r_q_min;
    logic [KEEP*DW-1:0]   r_q_max;
    logic                 r_q_vld;

    // working row
    logic [DW-1:0]        r_start;
    logic [TOTAL_W-1:0]   r_total;
    logic [CALLS_W-1:0]   r_calls;
    logic [DW-1:0]        r_mn [KEEP];
    logic [DW-1:0]        r_mx [KEEP];
    logic [KEEP*DW-1:0]   w_pk_min;
    logic [KEEP*DW-1:0]   w_pk_max;

    // end / query work
    logic [DW-1:0]        r_dur;
    logic [DW-1:0]        r_cmin;
    logic [DW-1:0]        r_cmax;
    logic                 r_insmn;
    logic                 r_insmx;
    logic [SW-1:0]        r_step;
    logic [TOTAL_W-1:0]   r_trim;
    logic [DW-1:0]        w_dur;
    logic [KW-1:0]        w_slot;
    logic [DW-1:0]        w_tval;
    logic [TOTAL_W:0]     w_tsum;
    logic [CALLS_W-1:0]   w_divisor;
    logic                 w_small;
    logic                 w_div_done;
    logic [AVG_W-1:0]     w_quo;
    logic [8:0]           w_reg_mod;
    logic                 w_ok;
    logic                 w_end_ok;
    logic                 w_qry_ok;
    logic                 w_has_reg;

    // output beat
    logic                 r_ovalid;
    logic [1:0]           r_o_status;
    logic [REGION_W-1:0]  r_o_region;
    logic [TS_W-1:0]      r_o_dur;
    logic [AVG_W-1:0]     r_o_avg;
    logic [TS_W-1:0]      r_o_min;
    logic [TS_W-1:0]      r_o_max;
    logic [CALLS_W-1:0]   r_o_calls;

    // region number modulo REGIONS, as a constant table over the 4-bit field
    always_comb begin
        w_reg_mod = '0;
        for (int v = 0; v < 16; v++) begin
            if (i_region == REGION_W'(v)) w_reg_mod = 9'(v % REGIONS);
        end
    end

    assign w_dur     = r_ts - r_start;
    assign w_slot    = i_cmd.trim_step ? KW'(r_step >> 1) : KW'(r_step);
    assign w_tval    = r_step[0] ? r_mx[w_slot] : r_mn[w_slot];
    assign w_tsum    = {1'b0, r_total} + (TOTAL_W + 1)'(r_dur);
    assign w_small   = (r_calls <= CALLS_W'(2 * KEEP));
    assign w_divisor = w_small ? r_calls : r_calls - CALLS_W'(2 * KEEP);
    assign w_ok      = (r_stat == STAT_OK);
    assign w_end_ok  = (r_mode == MODE_END) && w_ok;
    assign w_qry_ok  = (r_mode == MODE_QUERY) && w_ok;
    assign w_has_reg = (r_mode == MODE_BEGIN) || (r_mode == MODE_QUERY) || w_end_ok;

    always_comb begin
        for (int k = 0; k < KEEP; k++) begin
            w_pk_min[k*DW +: DW] = r_mn[k];
            w_pk_max[k*DW +: DW] = r_mx[k];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.push)     r_level <= r_level + LW'(1);
            if (i_cmd.pop_rd)   r_level <= r_level - LW'(1);
            if (i_cmd.clr_used) r_used  <= '0;
            if (i_cmd.row_wr)   r_used[r_idx] <= 1'b1;
            if (i_cmd.res_load)              r_ovalid <= 1'b1;
            else if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
        end
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.push)   r_stack[r_level[SIW-1:0]] <= r_idx;
        if (i_cmd.pop_rd) r_stk_q <= r_stack[SIW'(r_level - LW'(1))];
    end

    // statistics memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            m_start[r_idx] <= r_start;
            m_total[r_idx] <= r_total;
            m_calls[r_idx] <= r_calls;
            m_min[r_idx]   <= w_pk_min;
            m_max[r_idx]   <= w_pk_max;
        end
        if (i_cmd.row_rd) begin
            r_q_start <= m_start[r_idx];
            r_q_total <= m_total[r_idx];
            r_q_calls <= m_calls[r_idx];
            r_q_min   <= m_min[r_idx];
            r_q_max   <= m_max[r_idx];
            r_q_vld   <= r_used[r_idx];
        end
    end

    // item and working row
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode <= t_mode'(i_mode);
            r_ts   <= DW'(i_timestamp);
            r_idx  <= RW'(w_reg_mod);
            r_stat <= STAT_OK;
        end
        if (i_cmd.set_err) begin
            case (r_mode)
                MODE_BEGIN: r_stat <= STAT_FULL;
                MODE_END:   r_stat <= STAT_EMPTY;
                MODE_QUERY: r_stat <= STAT_NOCALL;
                default:    r_stat <= STAT_OK;
            endcase
        end
        if (i_cmd.pop_take) r_idx <= r_stk_q;
        if (i_cmd.row_load) begin
            // a row never written since the last clear reads as zero
            r_start <= r_q_vld ? r_q_start : '0;
            r_total <= r_q_vld ? r_q_total : '0;
            r_calls <= r_q_vld ? r_q_calls : '0;
            for (int k = 0; k < KEEP; k++) begin
                r_mn[k] <= r_q_vld ? r_q_min[k*DW +: DW] : '0;
                r_mx[k] <= r_q_vld ? r_q_max[k*DW +: DW] : '0;
            end
        end
        if (i_cmd.beg_upd) begin
            if (r_calls != '1) r_calls <= r_calls + CALLS_W'(1);
            r_start <= r_ts;
        end
        if (i_cmd.dur_calc) begin
            r_dur   <= w_dur;
            r_cmin  <= w_dur;
            r_cmax  <= w_dur;
            r_insmn <= (w_dur < r_mn[KEEP-1]) || (r_mn[KEEP-1] == '0);
            r_insmx <= (w_dur > r_mx[KEEP-1]);
            r_step  <= '0;
        end
        if (i_cmd.ins_step) begin
            // zero marks an empty slot in the ascending list
            if (r_insmn && ((r_cmin <= r_mn[w_slot]) || (r_mn[w_slot] == '0))) begin
                r_mn[w_slot] <= r_cmin;
                r_cmin       <= r_mn[w_slot];
            end
            if (r_insmx && (r_cmax >= r_mx[w_slot])) begin
                r_mx[w_slot] <= r_cmax;
                r_cmax       <= r_mx[w_slot];
            end
            r_step <= r_step + SW'(1);
        end
        if (i_cmd.tot_upd) r_total <= w_tsum[TOTAL_W] ? '1 : w_tsum[TOTAL_W-1:0];
        if (i_cmd.trim_init) begin
            r_trim <= r_total;
            r_step <= '0;
        end
        if (i_cmd.trim_step) begin
            r_trim <= (r_trim > TOTAL_W'(w_tval)) ? r_trim - TOTAL_W'(w_tval) : '0;
            r_step <= r_step + SW'(1);
        end
    end

    nrls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_trim),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_o_status <= r_stat;
            r_o_region <= w_has_reg ? REGION_W'(r_idx) : '0;
            r_o_dur    <= w_end_ok ? TS_W'(r_dur) : '0;
            r_o_avg    <= w_qry_ok ? w_quo : '0;
            r_o_min    <= w_qry_ok ? TS_W'(r_mn[0]) : '0;
            r_o_max    <= w_qry_ok ? TS_W'(r_mx[0]) : '0;
            r_o_calls  <= w_qry_ok ? r_calls : '0;
        end
    end

    assign o_sts.mode        = r_mode;
    assign o_sts.full        = (r_level >= LW'(STACK_DEPTH));
    assign o_sts.empty       = (r_level == '0);
    assign o_sts.calls_zero  = (r_calls == '0);
    assign o_sts.calls_small = w_small;
    assign o_sts.ins_last    = (r_step == SW'(KEEP - 1));
    assign o_sts.trim_last   = (r_step == SW'(2 * KEEP - 1));
    assign o_sts.div_done    = w_div_done;
    assign o_sts.out_taken   = r_ovalid && i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_status    = r_o_status;
    assign o_region    = r_o_region;
    assign o_duration  = r_o_dur;
    assign o_average   = r_o_avg;
    assign o_minimum   = r_o_min;
    assign o_maximum   = r_o_max;
    assign o_calls     = r_o_calls;

endmodule

>>> design/nrls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrls_checker
// Port-level checks of the latency statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module nrls_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [nrls_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic [1:0]                      i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [nrls_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [1:0]                      o_m_tuser
);
    import nrls_pkg::*;

    // one item in flight: no new beat taken while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after accept");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result beat changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != STAT_OK)) |->
            (o_m_tdata[OUT_CLS_HI:OUT_DUR_LO] == '0))
        else $error("error beat carries values");

endmodule

bind nested_region_latency_statistics_top nrls_checker u_nrls_checker (.*);

>>> dv/tb_nested_region_latency_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_region_latency_statistics_top
// Drives begin/end/reset/query beats with random gaps, predicts each result beat in a
// scoreboard class and compares the whole beat, printing fields on the first 10 mismatches.
// ----------------------------------------------------------------------------
module tb_nested_region_latency_statistics_top;
    import nrls_pkg::*;

    localparam int NREG  = 16;
    localparam int KEEPN = 4;
    localparam int DEPTH = 16;
    localparam longint unsigned LIMIT = 3000000;

    typedef struct packed {
        t_status          status;
        logic [3:0]       region;
        logic [47:0]      duration;
        logic [63:0]      average;
        logic [47:0]      minimum;
        logic [47:0]      maximum;
        logic [31:0]      calls;
    } t_result;

    class latency_scoreboard;
        bit          used [NREG];
        logic [47:0] start_ts [NREG];
        logic [63:0] total [NREG];
        logic [31:0] ncalls [NREG];
        logic [47:0] lo_list [NREG][KEEPN];
        logic [47:0] hi_list [NREG][KEEPN];
        logic [3:0]  stack [DEPTH];
        int          level;
        t_result     pending [$];
        int          mismatches;

        function new();
            level = 0;
            mismatches = 0;
            foreach (used[r]) begin
                used[r] = 0; start_ts[r] = 0; total[r] = 0; ncalls[r] = 0;
                for (int k = 0; k < KEEPN; k++) begin
                    lo_list[r][k] = 0; hi_list[r][k] = 0;
                end
            end
        endfunction

        function void clear_rows(int r);
            for (int k = 0; k < KEEPN; k++) begin
                lo_list[r][k] = 0; hi_list[r][k] = 0;
            end
        endfunction

        function void record_duration(int r, logic [47:0] d);
            logic [47:0] carry, prev;
            if (d < lo_list[r][KEEPN-1] || lo_list[r][KEEPN-1] == 0) begin
                carry = d;
                for (int k = 0; k < KEEPN; k++)
                    if (carry <= lo_list[r][k] || lo_list[r][k] == 0) begin
                        prev = lo_list[r][k]; lo_list[r][k] = carry; carry = prev;
                    end
            end
            if (d > hi_list[r][KEEPN-1]) begin
                carry = d;
                for (int k = 0; k < KEEPN; k++)
                    if (carry >= hi_list[r][k]) begin
                        prev = hi_list[r][k]; hi_list[r][k] = carry; carry = prev;
                    end
            end
            if (total[r] > ~64'd0 - d) total[r] = ~64'd0;
            else total[r] = total[r] + d;
        endfunction

        // Predict the result beat for one accepted input beat.
        function void note_input(t_mode mode, logic [3:0] r, logic [47:0] ts);
            t_result e;
            logic [63:0] t, a, b;
            int p;
            e = '0;
            case (mode)
                MODE_BEGIN: begin
                    e.region = r;
                    if (level >= DEPTH) e.status = STAT_FULL;
                    else begin
                        stack[level] = r; level++;
                        if (!used[r]) begin used[r] = 1; clear_rows(r); end
                        if (ncalls[r] != 32'hFFFF_FFFF) ncalls[r]++;
                        start_ts[r] = ts;
                    end
                end
                MODE_END: begin
                    if (level == 0) e.status = STAT_EMPTY;
                    else begin
                        level--; p = stack[level];
                        e.region = p;
                        e.duration = ts - start_ts[p];
                        record_duration(p, e.duration);
                    end
                end
                MODE_RESET: begin
                    for (int i = 0; i < NREG; i++)
                        if (used[i]) begin
                            start_ts[i] = 0; total[i] = 0; ncalls[i] = 0; clear_rows(i);
                        end
                end
                default: begin
                    e.region = r;
                    if (ncalls[r] == 0) e.status = STAT_NOCALL;
                    else begin
                        t = total[r];
                        if (ncalls[r] <= 2 * KEEPN) e.average = t / ncalls[r];
                        else begin
                            for (int k = 0; k < KEEPN; k++) begin
                                a = lo_list[r][k]; b = hi_list[r][k];
                                t = (t > a) ? t - a : 0;
                                t = (t > b) ? t - b : 0;
                            end
                            e.average = t / (64'(ncalls[r]) - 2 * KEEPN);
                        end
                        e.minimum = lo_list[r][0];
                        e.maximum = hi_list[r][0];
                        e.calls = ncalls[r];
                    end
                end
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp st=%0d rg=%0d dur=%0d avg=%0d min=%0d max=%0d c=%0d",
                        e.status, e.region, e.duration, e.average, e.minimum, e.maximum,
                        e.calls);
                    $display("          got st=%0d rg=%0d dur=%0d avg=%0d min=%0d max=%0d c=%0d",
                        got.status, got.region, got.duration, got.average,
                        got.minimum, got.maximum, got.calls);
                end
            end
        endfunction
    endclass

    // Result beat fields, taken from their tdata positions.
    function automatic t_result unpack_result(logic [1:0] st, logic [247:0] d);
        t_result g;
        g.status   = t_status'(st);
        g.region   = d[3:0];
        g.duration = d[51:4];
        g.average  = d[115:52];
        g.minimum  = d[163:116];
        g.maximum  = d[211:164];
        g.calls    = d[243:212];
        return g;
    endfunction

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [247:0] m_tdata;
    logic [1:0]  m_tuser;

    latency_scoreboard board = new();
    bit          hold_off = 0;
    longint unsigned cycle_count = 0;
    logic [47:0] now_ts = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    nested_region_latency_statistics_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    // Input beats are noted, result beats checked, on the rising edge.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_tvalid && s_tready)
            board.note_input(t_mode'(s_tuser), s_tdata[3:0], s_tdata[51:4]);
        if (i_rst_n && m_tvalid && m_tready)
            board.check_result(unpack_result(m_tuser, m_tdata));
        if (cycle_count > LIMIT) begin
            $display("tb_nested_region_latency_statistics_top: FAIL");
            $finish;
        end
    end

    // One beat with a random lead-in gap; tvalid stays high across back-to-back beats.
    task automatic send_beat(t_mode mode, logic [3:0] r, logic [47:0] ts);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            @(negedge i_clk) s_tvalid <= 0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, ts, r};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Timestamps advance by small random steps, 0 to 3000.
    task automatic send_timed(t_mode mode, logic [3:0] r);
        now_ts = now_ts + $urandom_range(0, 3000);
        send_beat(mode, r, now_ts);
    endtask

    // Receiver: random stall per beat, plus one long hold-off.
    initial begin
        int wait_n;
        forever begin
            @(negedge i_clk);
            if (hold_off) m_tready <= 0;
            else begin
                wait_n = $urandom_range(0, 19);
                if ($urandom_range(0, 3) == 0) wait_n = 0;
                if (wait_n > 0) begin
                    m_tready <= 0;
                    repeat (wait_n) @(negedge i_clk);
                end
                m_tready <= 1;
                @(posedge i_clk);
                while (!m_tvalid && !hold_off) @(posedge i_clk);
            end
        end
    end

    initial begin
        hold_off = 0;
        repeat (600) @(posedge i_clk);
        hold_off = 1;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        int depth, r, n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        // Directed: empty end, no-call query, extremes, wrap, zero duration, overflow.
        send_beat(MODE_END, 4'hF, 48'hFFFF_FFFF_FFFF);
        send_beat(MODE_QUERY, 4'h0, 48'd0);
        send_beat(MODE_BEGIN, 4'hF, 48'hFFFF_FFFF_FFF0);
        send_beat(MODE_END, 4'h0, 48'h0000_0000_0010);
        send_beat(MODE_BEGIN, 4'h0, 48'h1234);
        send_beat(MODE_END, 4'h0, 48'h1234);
        send_beat(MODE_QUERY, 4'hF, 48'd0);
        send_beat(MODE_QUERY, 4'h0, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 17; i++) send_beat(MODE_BEGIN, 4'(i), 48'(i * 7));
        for (int i = 0; i < 17; i++) send_beat(MODE_END, 4'h0, 48'(1000 + i * 13));
        send_beat(MODE_QUERY, 4'h5, 48'd0);
        send_beat(MODE_RESET, 4'hA, 48'h5555_5555_5555);
        send_beat(MODE_QUERY, 4'h5, 48'd0);

        // Random: mostly well-nested begin/end runs on few regions, queries, noise.
        n = 0;
        while (n < 400) begin
            case ($urandom_range(0, 9))
                0: begin send_beat(t_mode'($urandom_range(0, 3)), 4'($urandom),
                                   {16'($urandom), 32'($urandom)}); n++; end
                1: begin send_timed(MODE_QUERY, 4'($urandom_range(0, 15))); n++; end
                2: if ($urandom_range(0, 7) == 0) begin
                       send_timed(MODE_RESET, 4'($urandom)); n++;
                   end
                default: begin
                    depth = $urandom_range(1, 18);
                    for (int i = 0; i < depth; i++) begin
                        r = $urandom_range(0, 3);
                        if ($urandom_range(0, 5) == 0) r = $urandom_range(0, 15);
                        send_timed(MODE_BEGIN, 4'(r));
                    end
                    for (int i = 0; i < depth + $urandom_range(0, 1); i++)
                        send_timed(MODE_END, 4'($urandom));
                    send_timed(MODE_QUERY, 4'($urandom_range(0, 3)));
                    n += 2 * depth + 1;
                end
            endcase
        end
        @(negedge i_clk) s_tvalid <= 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("tb_nested_region_latency_statistics_top: PASS");
        else
            $display("tb_nested_region_latency_statistics_top: FAIL");
        $finish;
    end
endmodule

>>> filelist.f
design/nrls_pkg.sv
design/nrls_div.sv
design/nrls_ctrl.sv
design/nrls_dpath.sv
design/nested_region_latency_statistics_top.sv
design/nrls_checker.sv
dv/tb_nested_region_latency_statistics_top.sv
